// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define PPG_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ppg assertion failed");

// checked at every edge, reset included
`define PPG_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ppg reset assertion failed");

`endif

// ===== rtl/ppg_pkg.sv =====
package ppg_pkg;

  localparam int WIDTH            = 256;
  localparam int HEIGHT           = 192;
  localparam int SINE_TABLE_DEPTH = 1024;

  localparam int X_W     = 8;
  localparam int Y_W     = 8;
  localparam int T_W     = 32;
  localparam int LEVEL_W = 16;
  localparam int SINE_W  = 16;

  localparam int FRAC_SHIFT = 16;
  localparam int FX_MAX     = ((2 ** X_W - 1) << FRAC_SHIFT) / WIDTH;
  localparam int FY_MAX     = ((2 ** Y_W - 1) << FRAC_SHIFT) / HEIGHT;
  localparam int FRAC_MAX   = (FX_MAX > FY_MAX) ? FX_MAX : FY_MAX;
  localparam int FRAC_W     = $clog2(FRAC_MAX + 1);

  // gains of the coordinate terms
  localparam int X_GAIN  = 8;
  localparam int Y_GAIN  = 7;
  localparam int XY_GAIN = 5;

  // time factors 1.3 and 0.7 in Q16
  localparam int K_W = 17;
  localparam logic [K_W-1:0] K_1P3_Q16 = K_W'(85197);
  localparam logic [K_W-1:0] K_0P7_Q16 = K_W'(45875);
  localparam int TK_PROD_W = T_W + K_W;
  localparam int T13_W     = TK_PROD_W - FRAC_SHIFT;

  // radians Q16 to a fraction of a turn
  localparam int RAD_W        = T13_W;
  localparam int TURN_W       = 20;
  localparam int TURN_SHIFT   = 28;
  localparam int TURN_PROD_W  = TURN_W + TURN_SHIFT;
  localparam int INV_W        = 30;
  localparam logic [INV_W-1:0] INV_TWO_PI_Q32 = INV_W'(683565276);

  localparam int IDX_W      = $clog2(SINE_TABLE_DEPTH);
  localparam int IDX_PROD_W = TURN_W + IDX_W;
  localparam int QTR        = SINE_TABLE_DEPTH / 4;
  localparam int QTR_W      = $clog2(QTR);

  localparam int ACC_W = 34;
  localparam logic signed [ACC_W-1:0] ACC_BIAS   = ACC_W'(64'sd2147483648);
  localparam logic [ACC_W-2:0]        ROUND_HALF = (ACC_W-1)'(32768);
  localparam int SINE_FRAC = 15;

  typedef struct packed {
    logic [X_W-1:0] pixel_x;
    logic [Y_W-1:0] pixel_y;
    logic [T_W-1:0] time_phase;
  } pixel_item_t;

  typedef struct packed {
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
    logic [T_W-1:0]    t;
    logic [T13_W-1:0]  t13;
    logic [T_W-1:0]    t07;
  } scale_item_t;

  typedef struct packed {
    logic [TURN_W-1:0] a1;
    logic [TURN_W-1:0] a2;
    logic [TURN_W-1:0] a3;
  } turn_item_t;

  typedef struct packed {
    logic signed [SINE_W-1:0] s1;
    logic signed [SINE_W-1:0] s2;
    logic signed [SINE_W-1:0] c3;
  } sine_item_t;

  typedef logic [FRAC_W-1:0] frac_x_tab_t [2 ** X_W];
  typedef logic [FRAC_W-1:0] frac_y_tab_t [2 ** Y_W];
  typedef logic signed [SINE_W-1:0] sine_tab_t [QTR];

  function automatic frac_x_tab_t build_frac_x();
    frac_x_tab_t tab;
    for (int i = 0; i < 2 ** X_W; i++) begin
      tab[i] = FRAC_W'((i << FRAC_SHIFT) / WIDTH);
    end
    return tab;
  endfunction

  function automatic frac_y_tab_t build_frac_y();
    frac_y_tab_t tab;
    for (int i = 0; i < 2 ** Y_W; i++) begin
      tab[i] = FRAC_W'((i << FRAC_SHIFT) / HEIGHT);
    end
    return tab;
  endfunction

  // q30 product truncated toward zero
  function automatic longint mul_q30(longint a, longint b);
    logic neg;
    longint unsigned ua;
    longint unsigned ub;
    longint unsigned p;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? unsigned'(-a) : unsigned'(a);
    ub  = (b < 0) ? unsigned'(-b) : unsigned'(b);
    p   = (ua * ub) >> 30;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  // polynomial sine of one table entry
  function automatic logic signed [SINE_W-1:0] sine_value(longint unsigned i);
    longint unsigned u;
    longint unsigned r;
    longint unsigned quad;
    longint z;
    longint z2;
    longint p;
    longint s;
    longint q;
    u    = (i << 24) / SINE_TABLE_DEPTH;
    quad = (u >> 22) & 64'd3;
    r    = u & 64'h3F_FFFF;
    if (quad[0]) begin
      r = 64'h40_0000 - r;
    end
    z  = longint'(r << 8);
    z2 = mul_q30(z, z);
    p  = 172272;
    p  = -5026994 + mul_q30(p, z2);
    p  = 85569306 + mul_q30(p, z2);
    p  = -693598668 + mul_q30(p, z2);
    p  = 1686629713 + mul_q30(p, z2);
    s  = mul_q30(p, z);
    if (s < 0) begin
      s = 0;
    end
    q = (s + 16384) >>> 15;
    if (q > 32767) begin
      q = 32767;
    end
    return (quad >= 2) ? SINE_W'(-q) : SINE_W'(q);
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    for (int j = 0; j < QTR; j++) begin
      tab[j] = sine_value(longint'(j));
    end
    return tab;
  endfunction

  localparam frac_x_tab_t FRAC_X_TABLE = build_frac_x();
  localparam frac_y_tab_t FRAC_Y_TABLE = build_frac_y();
  localparam sine_tab_t   SINE_TABLE   = build_sine();
  localparam logic signed [SINE_W-1:0] SINE_PEAK = sine_value(longint'(QTR));

  // radians q16 to a turn fraction, modulo one turn
  function automatic logic [TURN_W-1:0] turn_of(logic [RAD_W-1:0] rad);
    logic [TURN_PROD_W-1:0] p_lo;
    logic [TURN_PROD_W-1:0] p_hi;
    logic [TURN_PROD_W-1:0] p;
    p_lo = TURN_PROD_W'(rad[31:0]) * TURN_PROD_W'(INV_TWO_PI_Q32);
    p_hi = TURN_PROD_W'(rad[RAD_W-1:32]) * TURN_PROD_W'(INV_TWO_PI_Q32);
    p    = p_lo + (p_hi << 32);
    return p[TURN_PROD_W-1:TURN_SHIFT];
  endfunction

  function automatic logic [IDX_W-1:0] turn_index(logic [TURN_W-1:0] a);
    logic [IDX_PROD_W-1:0] p;
    p = IDX_PROD_W'(a) * IDX_PROD_W'(SINE_TABLE_DEPTH);
    return p[IDX_PROD_W-1:TURN_W];
  endfunction

  function automatic logic [IDX_W-1:0] cos_index(logic [IDX_W-1:0] i);
    logic [IDX_W:0] sum;
    sum = (IDX_W+1)'(i) + (IDX_W+1)'(QTR);
    if (sum >= (IDX_W+1)'(SINE_TABLE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(SINE_TABLE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // full period read from the quarter wave table
  function automatic logic signed [SINE_W-1:0] sine_lookup(logic [IDX_W-1:0] i);
    logic [1:0] quad;
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] mirror;
    logic signed [SINE_W-1:0] mag;
    if (i >= IDX_W'(3 * QTR)) begin
      quad = 2'd3;
      base = IDX_W'(3 * QTR);
    end else if (i >= IDX_W'(2 * QTR)) begin
      quad = 2'd2;
      base = IDX_W'(2 * QTR);
    end else if (i >= IDX_W'(QTR)) begin
      quad = 2'd1;
      base = IDX_W'(QTR);
    end else begin
      quad = 2'd0;
      base = '0;
    end
    j      = i - base;
    mirror = IDX_W'(QTR) - j;
    if (!quad[0]) begin
      mag = SINE_TABLE[j[QTR_W-1:0]];
    end else if (j == '0) begin
      mag = SINE_PEAK;
    end else begin
      mag = SINE_TABLE[mirror[QTR_W-1:0]];
    end
    return quad[1] ? -mag : mag;
  endfunction

endpackage

// ===== rtl/ppg_pixel_if.sv =====
interface ppg_pixel_if import ppg_pkg::*;;
  logic           valid;
  logic           ready;
  logic [X_W-1:0] pixel_x;
  logic [Y_W-1:0] pixel_y;
  logic [T_W-1:0] time_phase;

  modport source (output valid, output pixel_x, output pixel_y, output time_phase,
                  input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input time_phase,
                output ready);
endinterface

// ===== rtl/ppg_level_if.sv =====
interface ppg_level_if import ppg_pkg::*;;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;

  modport source (output valid, output level, input ready);
  modport sink (input valid, input level, output ready);
endinterface

// ===== rtl/ppg_scale.sv =====
module ppg_scale import ppg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  output logic        up_ready,
  input  pixel_item_t up_item,
  output logic        down_valid,
  input  logic        down_ready,
  output scale_item_t down_item
);

  logic        valid;
  scale_item_t item;
  scale_item_t item_next;
  logic [TK_PROD_W-1:0] p13;
  logic [TK_PROD_W-1:0] p07;

  always_comb begin
    p13 = TK_PROD_W'(up_item.time_phase) * TK_PROD_W'(K_1P3_Q16);
    p07 = TK_PROD_W'(up_item.time_phase) * TK_PROD_W'(K_0P7_Q16);
    item_next.fx  = FRAC_X_TABLE[up_item.pixel_x];
    item_next.fy  = FRAC_Y_TABLE[up_item.pixel_y];
    item_next.t   = up_item.time_phase;
    item_next.t13 = p13[TK_PROD_W-1:FRAC_SHIFT];
    item_next.t07 = p07[FRAC_SHIFT+T_W-1:FRAC_SHIFT];
  end

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item <= item_next;
    end
  end

  assign down_valid = valid;
  assign down_item  = item;

endmodule

// ===== rtl/ppg_turn.sv =====
module ppg_turn import ppg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  output logic        up_ready,
  input  scale_item_t up_item,
  output logic        down_valid,
  input  logic        down_ready,
  output turn_item_t  down_item
);

  logic       valid;
  turn_item_t item;
  turn_item_t item_next;
  logic [RAD_W-1:0] x_rad;
  logic [RAD_W-1:0] y_rad;
  logic [RAD_W-1:0] xy_rad;

  always_comb begin
    x_rad  = RAD_W'(up_item.fx) * RAD_W'(X_GAIN);
    y_rad  = RAD_W'(up_item.fy) * RAD_W'(Y_GAIN);
    xy_rad = (RAD_W'(up_item.fx) + RAD_W'(up_item.fy)) * RAD_W'(XY_GAIN);
    item_next.a1 = turn_of(x_rad) + turn_of(RAD_W'(up_item.t));
    item_next.a2 = turn_of(y_rad) + turn_of(up_item.t13);
    item_next.a3 = turn_of(xy_rad) - turn_of(RAD_W'(up_item.t07));
  end

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item <= item_next;
    end
  end

  assign down_valid = valid;
  assign down_item  = item;

endmodule

// ===== rtl/ppg_sine.sv =====
module ppg_sine import ppg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  output logic       up_ready,
  input  turn_item_t up_item,
  output logic       down_valid,
  input  logic       down_ready,
  output sine_item_t down_item
);

  logic       valid;
  sine_item_t item;
  sine_item_t item_next;

  always_comb begin
    item_next.s1 = sine_lookup(turn_index(up_item.a1));
    item_next.s2 = sine_lookup(turn_index(up_item.a2));
    item_next.c3 = sine_lookup(cos_index(turn_index(up_item.a3)));
  end

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item <= item_next;
    end
  end

  assign down_valid = valid;
  assign down_item  = item;

endmodule

// ===== rtl/ppg_mix.sv =====
module ppg_mix import ppg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  sine_item_t         up_item,
  output logic               down_valid,
  input  logic               down_ready,
  output logic [LEVEL_W-1:0] down_level
);

  logic                        valid;
  logic [LEVEL_W-1:0]          level;
  logic [LEVEL_W-1:0]          level_next;
  logic signed [2*SINE_W-1:0]  prod;
  logic signed [ACC_W-1:0]     acc;
  logic [ACC_W-2:0]            rounded;
  logic [ACC_W-2-LEVEL_W:0]    scaled;

  always_comb begin
    prod    = up_item.s2 * up_item.c3;
    acc     = ACC_BIAS + (ACC_W'(up_item.s1) <<< SINE_FRAC) + ACC_W'(prod);
    rounded = acc[ACC_W-2:0] + ROUND_HALF;
    scaled  = rounded[ACC_W-2:LEVEL_W];
    if (acc[ACC_W-1]) begin
      level_next = '0;
    end else if (scaled > (ACC_W-1-LEVEL_W)'({LEVEL_W{1'b1}})) begin
      level_next = '1;
    end else begin
      level_next = scaled[LEVEL_W-1:0];
    end
  end

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      level <= level_next;
    end
  end

  assign down_valid = valid;
  assign down_level = level;

endmodule

// ===== rtl/plasma_pixel_generator_unit.sv =====
// channel  | role   | payload
// pixel    | sink   | pixel_x, pixel_y, time_phase
// shade    | source | level
//
// one item per cycle unless the output stalls; each result passes the stages below in order
// stages: input register, scale, turn, sine lookup, output register
// each stage loads when it is empty or its successor moves on
// a stalled output holds its item while earlier stages keep filling
// rst clears every stage valid flag; payload registers keep their value
module plasma_pixel_generator_unit import ppg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ppg_pixel_if.sink   pixel,
  ppg_level_if.source shade
);

  logic        in_valid;
  pixel_item_t in_item;
  logic        scale_up_ready;
  logic        scale_valid;
  scale_item_t scale_item;
  logic        turn_up_ready;
  logic        turn_valid;
  turn_item_t  turn_item;
  logic        sine_up_ready;
  logic        sine_valid;
  sine_item_t  sine_item;
  logic        mix_up_ready;

  assign pixel.ready = !in_valid || scale_up_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pixel.ready) begin
      in_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.ready && pixel.valid) begin
      in_item.pixel_x    <= pixel.pixel_x;
      in_item.pixel_y    <= pixel.pixel_y;
      in_item.time_phase <= pixel.time_phase;
    end
  end

  ppg_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (in_valid),
    .up_ready   (scale_up_ready),
    .up_item    (in_item),
    .down_valid (scale_valid),
    .down_ready (turn_up_ready),
    .down_item  (scale_item)
  );

  ppg_turn u_turn (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (scale_valid),
    .up_ready   (turn_up_ready),
    .up_item    (scale_item),
    .down_valid (turn_valid),
    .down_ready (sine_up_ready),
    .down_item  (turn_item)
  );

  ppg_sine u_sine (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (turn_valid),
    .up_ready   (sine_up_ready),
    .up_item    (turn_item),
    .down_valid (sine_valid),
    .down_ready (mix_up_ready),
    .down_item  (sine_item)
  );

  ppg_mix u_mix (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (sine_valid),
    .up_ready   (mix_up_ready),
    .up_item    (sine_item),
    .down_valid (shade.valid),
    .down_ready (shade.ready),
    .down_level (shade.level)
  );

endmodule

// ===== rtl/ppg_checker.sv =====
`include "assert_macros.svh"

module ppg_checker import ppg_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [LEVEL_W-1:0] level
);

  `PPG_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid && in_ready)

  `PPG_ASSERT(a_ready_when_drained, clk, rst, !out_valid |-> in_ready)

  `PPG_ASSERT(a_latency, clk, rst, in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)

  `PPG_ASSERT(a_stall_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(level))

endmodule

bind plasma_pixel_generator_unit ppg_checker u_ppg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixel.valid),
  .in_ready  (pixel.ready),
  .out_valid (shade.valid),
  .out_ready (shade.ready),
  .level     (shade.level)
);
